>>> src/oamr_pkg.sv
// Shared types, codes and constants for the operand addressing mode resolver.
package oamr_pkg;

    // Default memory depth in 16-bit words
    localparam int DEF_MEM_WORDS = 4096;

    // Request kinds carried in the mode field
    localparam logic [1:0] KIND_WR_REG  = 2'd0;
    localparam logic [1:0] KIND_WR_MEM  = 2'd1;
    localparam logic [1:0] KIND_RESOLVE = 2'd2;

    // First register that always steps by a word (stack pointer)
    localparam logic [2:0] REG_SP = 3'd6;

    // Operand addressing modes, bits 5:3 of the specifier
    typedef enum logic [2:0] {
        AM_REG,
        AM_DEF,
        AM_AUTOINC,
        AM_AUTOINC_DEF,
        AM_AUTODEC,
        AM_AUTODEC_DEF,
        AM_INDEX,
        AM_INDEX_DEF
    } am_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_IND,
        ST_DATA
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear_wr;   // write zero at clear pointer, advance it
        logic load_reg;   // register write request
        logic load_mem;   // memory write request
        logic capture;    // latch resolve request
        logic addr_step;  // first address, register update, first read
        logic ind_step;   // take pointer word, second read
        logic res_fast;   // result from register file alone
        logic res_data;   // result from memory read data
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last;
        am_t  am;
    } sts_t;

    // Sign extend a byte to a word
    function automatic logic [15:0] sext8(input logic [7:0] b);
        return {{8{b[7]}}, b};
    endfunction

endpackage

>>> src/oamr_if.sv
// Request and response channel interfaces of the operand addressing mode resolver.
interface oamr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [5:0]  operand_spec;
    logic        byte_operation;
    logic [2:0]  write_register;
    logic [15:0] write_address;
    logic [15:0] write_data;

    modport source (
        output valid, mode, operand_spec, byte_operation, write_register,
               write_address, write_data,
        input  ready
    );
    modport sink (
        input  valid, mode, operand_spec, byte_operation, write_register,
               write_address, write_data,
        output ready
    );
endinterface

interface oamr_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] operand_address;
    logic [15:0] operand_value;
    logic        register_operand;
    logic        unsupported_mode;

    modport source (
        output valid, operand_address, operand_value, register_operand,
               unsupported_mode,
        input  ready
    );
    modport sink (
        input  valid, operand_address, operand_value, register_operand,
               unsupported_mode,
        output ready
    );
endinterface

>>> src/operand_addressing_mode_resolver.sv
// Top level of the operand addressing mode resolver.
//
// Requests enter on req: a register write, a memory word write or an
// operand resolve (6-bit specifier plus byte flag). Only resolve requests
// produce a response on rsp: effective address (register number in
// register mode), operand value, register flag and unsupported-mode flag.
// Writes are done in the idle state, which stays ready for the next request.
// A resolve request holds the request channel while it steps through:
//   ADDR alone in register mode and modes 6/7,
//   ADDR and DATA in deferred, autoincrement and autodecrement modes,
//   ADDR, IND and DATA in the two deferred auto modes,
// as the single memory port takes one dependent word read per step.
// The response turns valid at the edge that ends the last step, the same
// edge at which req.ready rises again.
// A waiting response does not block write requests; a later resolve waits
// in its last step until the response register is free.
// After reset the register file reads zero and the memory is cleared by a
// pass that writes zero to every word, during which req.ready stays low.
module operand_addressing_mode_resolver #(
    parameter int MEM_WORDS = oamr_pkg::DEF_MEM_WORDS
) (
    input logic         clk,
    input logic         rst_n,
    oamr_req_if.sink    req,
    oamr_rsp_if.source  rsp
);

    oamr_pkg::cmd_t cmd;
    oamr_pkg::sts_t sts;

    oamr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_mode  (req.mode),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    oamr_datapath #(
        .MEM_WORDS (MEM_WORDS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .operand_spec     (req.operand_spec),
        .byte_operation   (req.byte_operation),
        .write_register   (req.write_register),
        .write_address    (req.write_address),
        .write_data       (req.write_data),
        .operand_address  (rsp.operand_address),
        .operand_value    (rsp.operand_value),
        .register_operand (rsp.register_operand),
        .unsupported_mode (rsp.unsupported_mode)
    );

endmodule

>>> src/oamr_ram.sv
// Generic single-port RAM with registered read.
module oamr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = oamr_pkg::DEF_MEM_WORDS,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end

endmodule

>>> src/oamr_datapath.sv
// Datapath: register file, address arithmetic, memory port and result register.
module oamr_datapath #(
    parameter int MEM_WORDS = oamr_pkg::DEF_MEM_WORDS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  oamr_pkg::cmd_t   cmd,
    output oamr_pkg::sts_t   sts,
    input  logic [5:0]       operand_spec,
    input  logic             byte_operation,
    input  logic [2:0]       write_register,
    input  logic [15:0]      write_address,
    input  logic [15:0]      write_data,
    output logic [15:0]      operand_address,
    output logic [15:0]      operand_value,
    output logic             register_operand,
    output logic             unsupported_mode
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [15:0] IDX_LIMIT = 16'(MEM_WORDS);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_WORDS - 1);

    logic [15:0]   rf_reg [8];
    logic [AW-1:0] clr_cnt_reg;
    logic [5:0]    spec_reg;
    logic          byte_reg;
    logic [15:0]   adr_reg;
    logic          oob_reg;
    logic [15:0]   res_addr_reg;
    logic [15:0]   res_val_reg;
    logic          res_isreg_reg;
    logic          res_unsup_reg;

    logic [2:0]        rnum;
    oamr_pkg::am_t     am;
    logic [15:0]       cur;
    logic [15:0]       step;
    logic [15:0]       inc;
    logic [15:0]       dec;
    logic [15:0]       first_addr;
    logic              writeback;
    logic [15:0]       ram_rdata;
    logic [15:0]       word;
    logic [15:0]       rd_addr;
    logic [14:0]       rd_idx;
    logic              rd_ok;
    logic [14:0]       wr_idx;
    logic              wr_ok;
    logic              ram_en;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [15:0]       ram_wdata;
    logic [7:0]        mem_byte;
    logic              is_reg_mode;

    // Decode of the latched specifier and register arithmetic
    assign rnum        = spec_reg[2:0];
    assign am          = oamr_pkg::am_t'(spec_reg[5:3]);
    assign cur         = rf_reg[rnum];
    assign step        = (byte_reg && (rnum < oamr_pkg::REG_SP)) ? 16'd1 : 16'd2;
    assign inc         = cur + step;
    assign dec         = cur - step;
    assign first_addr  = spec_reg[5] ? dec : cur;
    assign writeback   = (am == oamr_pkg::AM_AUTOINC) || (am == oamr_pkg::AM_AUTOINC_DEF) ||
                         (am == oamr_pkg::AM_AUTODEC) || (am == oamr_pkg::AM_AUTODEC_DEF);
    assign is_reg_mode = (am == oamr_pkg::AM_REG);

    // Read data, forced to zero when the address was beyond memory
    assign word     = oob_reg ? 16'd0 : ram_rdata;
    assign mem_byte = adr_reg[0] ? word[15:8] : word[7:0];

    // Memory index checks
    assign rd_addr = cmd.ind_step ? word : first_addr;
    assign rd_idx  = rd_addr[15:1];
    assign rd_ok   = {1'b0, rd_idx} < IDX_LIMIT;
    assign wr_idx  = write_address[15:1];
    assign wr_ok   = {1'b0, wr_idx} < IDX_LIMIT;

    // Memory port selection
    always_comb
    begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = rd_idx[AW-1:0];
        ram_wdata = write_data;
        priority if (cmd.clear_wr)
        begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_reg;
            ram_wdata = 16'd0;
        end
        else if (cmd.load_mem)
        begin
            ram_en   = wr_ok;
            ram_we   = 1'b1;
            ram_addr = wr_idx[AW-1:0];
        end
        else
        begin
            ram_en = (cmd.addr_step || cmd.ind_step) && rd_ok;
        end
    end

    oamr_ram #(
        .WIDTH (16),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Register file and clear pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                rf_reg[i] <= 16'd0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.load_reg)
                rf_reg[write_register] <= write_data;
            else if (cmd.addr_step && writeback)
                rf_reg[rnum] <= spec_reg[5] ? dec : inc;
            if (cmd.clear_wr)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Request latch, address tracking and result register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            spec_reg <= operand_spec;
            byte_reg <= byte_operation;
        end
        if (cmd.addr_step)
        begin
            adr_reg <= first_addr;
            oob_reg <= !rd_ok;
        end
        else if (cmd.ind_step)
        begin
            adr_reg <= word;
            oob_reg <= !rd_ok;
        end
        if (cmd.res_fast)
        begin
            res_addr_reg  <= is_reg_mode ? {13'd0, rnum} : 16'd0;
            res_val_reg   <= is_reg_mode ?
                             (byte_reg ? oamr_pkg::sext8(cur[7:0]) : cur) : 16'd0;
            res_isreg_reg <= is_reg_mode;
            res_unsup_reg <= !is_reg_mode;
        end
        else if (cmd.res_data)
        begin
            res_addr_reg  <= adr_reg;
            res_val_reg   <= byte_reg ? oamr_pkg::sext8(mem_byte) : word;
            res_isreg_reg <= 1'b0;
            res_unsup_reg <= 1'b0;
        end
    end

    assign sts = '{clear_last: (clr_cnt_reg == CLR_LAST), am: am};

    assign operand_address  = res_addr_reg;
    assign operand_value    = res_val_reg;
    assign register_operand = res_isreg_reg;
    assign unsupported_mode = res_unsup_reg;

endmodule

>>> src/oamr_ctrl.sv
// Controller: sequences memory clearing, load requests and operand resolution.
module oamr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  logic [1:0]     req_mode,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    input  oamr_pkg::sts_t sts,
    output oamr_pkg::cmd_t cmd
);

    oamr_pkg::state_t state_reg;
    oamr_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    // Result register can take a new response
    assign out_free = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oamr_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            oamr_pkg::ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                    state_next = oamr_pkg::ST_IDLE;
            end
            oamr_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_mode)
                        oamr_pkg::KIND_WR_REG:  cmd.load_reg = 1'b1;
                        oamr_pkg::KIND_WR_MEM:  cmd.load_mem = 1'b1;
                        oamr_pkg::KIND_RESOLVE:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = oamr_pkg::ST_ADDR;
                        end
                        default: ;
                    endcase
                end
            end
            oamr_pkg::ST_ADDR:
            begin
                unique case (sts.am)
                    oamr_pkg::AM_REG, oamr_pkg::AM_INDEX, oamr_pkg::AM_INDEX_DEF:
                    begin
                        if (out_free)
                        begin
                            cmd.res_fast = 1'b1;
                            state_next   = oamr_pkg::ST_IDLE;
                        end
                    end
                    oamr_pkg::AM_DEF, oamr_pkg::AM_AUTOINC, oamr_pkg::AM_AUTODEC:
                    begin
                        cmd.addr_step = 1'b1;
                        state_next    = oamr_pkg::ST_DATA;
                    end
                    oamr_pkg::AM_AUTOINC_DEF, oamr_pkg::AM_AUTODEC_DEF:
                    begin
                        cmd.addr_step = 1'b1;
                        state_next    = oamr_pkg::ST_IND;
                    end
                endcase
            end
            oamr_pkg::ST_IND:
            begin
                cmd.ind_step = 1'b1;
                state_next   = oamr_pkg::ST_DATA;
            end
            oamr_pkg::ST_DATA:
            begin
                if (out_free)
                begin
                    cmd.res_data = 1'b1;
                    state_next   = oamr_pkg::ST_IDLE;
                end
            end
            default: state_next = oamr_pkg::ST_IDLE;
        endcase
    end

    // Response valid flag
    always_comb
    begin
        if (cmd.res_fast || cmd.res_data)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign req_ready = (state_reg == oamr_pkg::ST_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule
